>>> hdl/ssn_pkg.sv
// Shared constants, types and sequencer states of the sparse softmax NLL unit.
package ssn_pkg;

    localparam int MAX_CANDIDATES = 64;
    localparam int AW             = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CNTW           = $clog2(MAX_CANDIDATES + 1);
    localparam int JW             = $clog2(MAX_CANDIDATES + 2);
    localparam int DW             = 17 + JW;
    localparam int EW             = $clog2(DW);
    localparam int FRAC_BITS      = 40;
    localparam int LEW            = ((EW > 5) ? EW : 5) + 1;
    localparam int LW             = LEW + FRAC_BITS;
    localparam int NORM_SHIFT     = 63 - DW;
    localparam int LN_EXP_BIAS    = 16;
    localparam int EXP_TERMS      = 6;
    localparam int EXP_SQUARES    = 16;
    localparam int NW             = $clog2(EXP_TERMS + 1);
    localparam int SQW            = $clog2(EXP_SQUARES);
    localparam int FCW            = $clog2(FRAC_BITS);
    localparam int RW             = 44;
    localparam int APB_AW         = 3;

    localparam logic [63:0] ONE_Q62   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] LN2_Q64   = 64'hB172_17F7_D1CF_79AB;
    localparam logic [63:0] ROUND_Q46 = 64'h0000_2000_0000_0000;
    localparam logic signed [15:0] UNSEEN_RESET = -16'sd20480;
    localparam logic [22:0] NLL_MAX = 23'h7F_FFFF;
    localparam logic [APB_AW-3:0] REG_UNSEEN = '0;

    typedef logic signed [15:0] score_t;
    typedef logic [19:0] token_t;
    typedef logic [22:0] nll_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic        shift87;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [2:0]  den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
    } div_rsp_t;

    typedef enum logic [12:0] {
        ST_LOAD   = 13'b0_0000_0000_0001,
        ST_SETUP  = 13'b0_0000_0000_0010,
        ST_FETCH  = 13'b0_0000_0000_0100,
        ST_KSET   = 13'b0_0000_0000_1000,
        ST_EMUL   = 13'b0_0000_0001_0000,
        ST_EDIV   = 13'b0_0000_0010_0000,
        ST_ESQ    = 13'b0_0000_0100_0000,
        ST_EACC   = 13'b0_0000_1000_0000,
        ST_LNSET  = 13'b0_0001_0000_0000,
        ST_NORM   = 13'b0_0010_0000_0000,
        ST_LSQ    = 13'b0_0100_0000_0000,
        ST_LN2    = 13'b0_1000_0000_0000,
        ST_FINISH = 13'b1_0000_0000_0000
    } state_t;

endpackage

>>> hdl/ssn_in_if.sv
// Input channel: one candidate item per transfer.
interface ssn_in_if;
    import ssn_pkg::*;

    logic   valid;
    logic   ready;
    score_t score;
    token_t candidate_token;
    token_t target_token;
    logic   present;
    logic   last;

    modport source (output valid, score, candidate_token, target_token, present, last,
                    input ready);
    modport sink   (input valid, score, candidate_token, target_token, present, last,
                    output ready);
endinterface

>>> hdl/ssn_out_if.sv
// Output channel: one loss result per transfer.
interface ssn_out_if;
    import ssn_pkg::*;

    logic valid;
    logic ready;
    nll_t nll;
    logic target_hit;
    logic saturated;

    modport source (output valid, nll, target_hit, saturated, input ready);
    modport sink   (input valid, nll, target_hit, saturated, output ready);
endinterface

>>> hdl/ssn_mul.sv
// Shared 64x64 multiplier, one 32x32 partial product per cycle, result >> 62 or >> 87.
module ssn_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  ssn_pkg::mul_req_t req,
    output ssn_pkg::mul_rsp_t rsp
);
    import ssn_pkg::*;

    logic         busy_reg;
    logic         done_reg;
    logic [1:0]   cnt_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic         sel_reg;
    logic [127:0] acc_reg;
    logic [31:0]  ah;
    logic [31:0]  bh;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    always_comb
    begin
        ah = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
        bh = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
        pp = ah * bh;
        case (cnt_reg)
            2'd0:    pp_sh = {64'b0, pp};
            2'd1:    pp_sh = {32'b0, pp, 32'b0};
            2'd2:    pp_sh = {32'b0, pp, 32'b0};
            2'd3:    pp_sh = {pp, 64'b0};
            default: pp_sh = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            sel_reg <= req.shift87;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = sel_reg ? {23'b0, acc_reg[127:87]} : acc_reg[125:62];

endmodule

>>> hdl/ssn_div.sv
// Divider of a 64-bit value by a small constant (1..6), eight quotient bits per cycle.
module ssn_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ssn_pkg::div_req_t req,
    output ssn_pkg::div_rsp_t rsp
);
    import ssn_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [2:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [63:0] q_reg;
    logic [2:0]  rem_reg;
    logic [2:0]  den_reg;
    logic [2:0]  r;
    logic [3:0]  t;
    logic [7:0]  qbits;

    always_comb
    begin
        r     = rem_reg;
        qbits = '0;
        for (int i = 0; i < 8; i++)
        begin
            t = {r, num_reg[63 - i]};
            if (t >= {1'b0, den_reg})
            begin
                qbits[7 - i] = 1'b1;
                r            = 3'(t - {1'b0, den_reg});
            end
            else
            begin
                r = t[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[55:0], 8'b0};
            q_reg   <= {q_reg[55:0], qbits};
            rem_reg <= r;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule

>>> hdl/ssn_cfg.sv
// APB register slice holding the unseen score.
module ssn_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssn_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ssn_pkg::score_t             unseen_score
);
    import ssn_pkg::*;

    score_t unseen_reg;
    logic   hit;

    assign hit = (paddr[APB_AW-1:2] == REG_UNSEEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unseen_reg <= UNSEEN_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            unseen_reg <= pwdata[15:0];
        end
    end

    assign prdata       = hit ? {{16{unseen_reg[15]}}, unseen_reg} : 32'b0;
    assign pready       = 1'b1;
    assign unseen_score = unseen_reg;

endmodule

>>> hdl/sparse_softmax_nll_unit.sv
// Top level of the sparse softmax negative log-likelihood unit.
//
// Candidates (token, score) stream in one per transfer and are stored at one
// item per cycle, up to MAX_CANDIDATES per list; later ones are dropped and flag
// the result as saturated. The transfer with last=1 closes the list and the
// block then stops taking input while a small sequencer walks the terms
// through one shared multi-cycle multiplier (one 32x32 partial product per
// cycle) and a small constant divider (eight quotient bits per cycle).
// Each exp term (the unseen bucket, every stored score, and the target score
// when the target was not among the candidates) takes six Taylor steps of
// multiply plus divide, then sixteen squarings. The log of the sum takes a
// one-bit-per-cycle normalize, forty squarings and the final scaling by
// ln 2. The result sits in an output register, so the next list can start
// loading while it waits to be taken. The unseen score is written through
// the APB port at address 0 (reset -20.0 in Q6.10) and should only be
// changed between lists.
module sparse_softmax_nll_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    ssn_in_if.sink                      in_ch,
    ssn_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssn_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ssn_pkg::*;

    // configuration
    score_t unseen_score;

    // shared arithmetic
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // sequencer and list state
    state_t            state_reg,   state_next;
    logic              issued_reg,  issued_next;
    logic [CNTW-1:0]   count_reg,   count_next;
    score_t            rmax_reg,    rmax_next;
    score_t            tval_reg,    tval_next;
    logic              found_reg,   found_next;
    logic              dropped_reg, dropped_next;
    logic              zero_reg,    zero_next;
    logic              out_valid_reg, out_valid_next;

    // datapath registers
    score_t            mx_reg,      mx_next;
    score_t            tscore_reg,  tscore_next;
    logic [JW-1:0]     j_reg,       j_next;
    logic [15:0]       k_reg,       k_next;
    logic [63:0]       term_reg,    term_next;
    logic [63:0]       r_reg,       r_next;
    logic [NW-1:0]     n_reg,       n_next;
    logic [SQW-1:0]    sq_reg,      sq_next;
    logic [DW-1:0]     d_reg,       d_next;
    logic [63:0]       m_reg,       m_next;
    logic [EW-1:0]     e_reg,       e_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [FCW-1:0]    fcnt_reg,    fcnt_next;
    nll_t              nll_reg,     nll_next;
    logic              seen_reg,    seen_next;
    logic              sat_reg,     sat_next;

    // score memory
    score_t            mem [MAX_CANDIDATES];
    score_t            rd_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [JW-1:0]     jm1;

    // combinational helpers
    logic              in_acc;
    logic              store_ok;
    logic              out_free;
    logic [JW-1:0]     cnt_j;
    logic [JW-1:0]     jn;
    score_t            s_sel;
    score_t            tsc;
    score_t            mx_a;
    logic signed [16:0] kdiff;
    logic signed [16:0] dm;
    logic [63:0]       t_val;
    logic [63:0]       rsum;
    logic [DW-1:0]     d_sum;
    logic signed [LEW-1:0] em16;
    logic signed [LW-1:0]  l_val;
    logic [LW-1:0]     mag;
    logic [41:0]       xsum;
    logic signed [RW-1:0] xs;
    logic signed [RW-1:0] dm_sh;
    logic signed [RW-1:0] res;

    ssn_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .unseen_score (unseen_score)
    );

    ssn_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    ssn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // handshakes
    assign in_ch.ready = (state_reg == ST_LOAD);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign store_ok    = (count_reg < CNTW'(MAX_CANDIDATES));
    assign out_free    = !out_valid_reg || out_ch.ready;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.nll         = nll_reg;
    assign out_ch.target_hit  = seen_reg;
    assign out_ch.saturated   = sat_reg;

    // memory ports: write while loading, read the term selected by j
    assign wr_en   = in_acc && in_ch.present && store_ok;
    assign wr_addr = count_reg[AW-1:0];
    assign jm1     = j_reg - JW'(1);
    assign rd_addr = jm1[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_ch.score;
        end
        rd_reg <= mem[rd_addr];
    end

    // operand steering for the shared units
    always_comb
    begin
        t_val = {12'b0, k_reg, 36'b0};       // k / 2^26 in Q.62

        // log2 result as signed Q.40, integer part e - 16
        em16  = $signed(LEW'(e_reg)) - $signed(LEW'(LN_EXP_BIAS));
        l_val = {em16, frac_reg};
        mag   = l_val[LW-1] ? LW'(-l_val) : LW'(l_val);

        mul_req.start   = !issued_reg && ((state_reg == ST_EMUL) || (state_reg == ST_ESQ)
                          || (state_reg == ST_LSQ) || (state_reg == ST_LN2));
        mul_req.a       = term_reg;
        mul_req.b       = t_val;
        mul_req.shift87 = 1'b0;
        case (state_reg)
            ST_ESQ:
            begin
                mul_req.a = r_reg;
                mul_req.b = r_reg;
            end
            ST_LSQ:
            begin
                mul_req.a = m_reg;
                mul_req.b = m_reg;
            end
            ST_LN2:
            begin
                mul_req.a       = 64'(mag);
                mul_req.b       = LN2_Q64;
                mul_req.shift87 = 1'b1;
            end
            default:
            begin
                mul_req.a = term_reg;
            end
        endcase

        div_req.start = !issued_reg && (state_reg == ST_EDIV);
        div_req.num   = mul_rsp.p;
        div_req.den   = 3'(n_reg);
    end

    // sequencer
    always_comb
    begin
        cnt_j = JW'(count_reg);
        jn    = j_reg + JW'(1);

        tsc   = found_reg ? tval_reg : unseen_score;
        mx_a  = (unseen_score > rmax_reg) ? unseen_score : rmax_reg;
        if (tsc > mx_a)
        begin
            mx_a = tsc;
        end

        if (j_reg == '0)
        begin
            s_sel = unseen_score;
        end
        else if (j_reg <= cnt_j)
        begin
            s_sel = rd_reg;
        end
        else
        begin
            s_sel = tscore_reg;
        end
        kdiff = {mx_reg[15], mx_reg} - {s_sel[15], s_sel};

        rsum  = r_reg + ROUND_Q46;
        d_sum = d_reg + DW'(rsum[62:46]);

        // final combine: ln(D) + (M - target) scaled to Q.16
        xsum  = {1'b0, mul_rsp.p[40:0]} + 42'd1;
        xs    = l_val[LW-1] ? -$signed(RW'(xsum[41:1])) : $signed(RW'(xsum[41:1]));
        dm    = {mx_reg[15], mx_reg} - {tscore_reg[15], tscore_reg};
        dm_sh = {{(RW-23){dm[16]}}, dm, 6'b0};
        res   = xs + dm_sh;

        state_next     = state_reg;
        issued_next    = issued_reg;
        count_next     = count_reg;
        rmax_next      = rmax_reg;
        tval_next      = tval_reg;
        found_next     = found_reg;
        dropped_next   = dropped_reg;
        zero_next      = zero_reg;
        mx_next        = mx_reg;
        tscore_next    = tscore_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        term_next      = term_reg;
        r_next         = r_reg;
        n_next         = n_reg;
        sq_next        = sq_reg;
        d_next         = d_reg;
        m_next         = m_reg;
        e_next         = e_reg;
        frac_next      = frac_reg;
        fcnt_next      = fcnt_reg;
        nll_next       = nll_reg;
        seen_next      = seen_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;

        if (mul_req.start || div_req.start)
        begin
            issued_next = 1'b1;
        end
        if (mul_rsp.done || div_rsp.done)
        begin
            issued_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (in_ch.present)
                    begin
                        if (store_ok)
                        begin
                            count_next = count_reg + CNTW'(1);
                            if (in_ch.score > rmax_reg)
                            begin
                                rmax_next = in_ch.score;
                            end
                            if (!found_reg && (in_ch.candidate_token == in_ch.target_token))
                            begin
                                found_next = 1'b1;
                                tval_next  = in_ch.score;
                            end
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    if (in_ch.last)
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end

            ST_SETUP:
            begin
                tscore_next = tsc;
                mx_next     = mx_a;
                j_next      = '0;
                d_next      = '0;
                state_next  = ST_FETCH;
            end

            ST_FETCH:
            begin
                state_next = ST_KSET;
            end

            ST_KSET:
            begin
                k_next     = kdiff[16] ? 16'd0 : kdiff[15:0];
                term_next  = ONE_Q62;
                r_next     = ONE_Q62;
                n_next     = NW'(1);
                state_next = ST_EMUL;
            end

            ST_EMUL:
            begin
                if (mul_rsp.done)
                begin
                    state_next = ST_EDIV;
                end
            end

            ST_EDIV:
            begin
                if (div_rsp.done)
                begin
                    // alternating Taylor series of exp(-t)
                    term_next = div_rsp.q;
                    r_next    = n_reg[0] ? (r_reg - div_rsp.q) : (r_reg + div_rsp.q);
                    if (n_reg == NW'(EXP_TERMS))
                    begin
                        sq_next    = '0;
                        state_next = ST_ESQ;
                    end
                    else
                    begin
                        n_next     = n_reg + NW'(1);
                        state_next = ST_EMUL;
                    end
                end
            end

            ST_ESQ:
            begin
                if (mul_rsp.done)
                begin
                    r_next  = mul_rsp.p;
                    sq_next = sq_reg + SQW'(1);
                    if (sq_reg == SQW'(EXP_SQUARES - 1))
                    begin
                        state_next = ST_EACC;
                    end
                end
            end

            ST_EACC:
            begin
                d_next = d_sum;
                j_next = jn;
                if ((jn <= cnt_j) || ((jn == cnt_j + JW'(1)) && !found_reg))
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    state_next = ST_LNSET;
                end
            end

            ST_LNSET:
            begin
                if (d_reg == '0)
                begin
                    zero_next  = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    m_next     = 64'(d_reg) << NORM_SHIFT;
                    e_next     = EW'(DW - 1);
                    state_next = ST_NORM;
                end
            end

            ST_NORM:
            begin
                if (m_reg[62])
                begin
                    fcnt_next  = '0;
                    frac_next  = '0;
                    state_next = ST_LSQ;
                end
                else
                begin
                    m_next = {m_reg[62:0], 1'b0};
                    e_next = e_reg - EW'(1);
                end
            end

            ST_LSQ:
            begin
                if (mul_rsp.done)
                begin
                    frac_next = {frac_reg[FRAC_BITS-2:0], mul_rsp.p[63]};
                    m_next    = mul_rsp.p[63] ? {1'b0, mul_rsp.p[63:1]} : mul_rsp.p;
                    fcnt_next = fcnt_reg + FCW'(1);
                    if (fcnt_reg == FCW'(FRAC_BITS - 1))
                    begin
                        state_next = ST_LN2;
                    end
                end
            end

            ST_LN2:
            begin
                if (mul_rsp.done)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    seen_next      = found_reg;
                    if (zero_reg)
                    begin
                        nll_next = '0;
                        sat_next = 1'b1;
                    end
                    else if (res < 0)
                    begin
                        nll_next = '0;
                        sat_next = 1'b1;
                    end
                    else if (res > $signed(RW'(NLL_MAX)))
                    begin
                        nll_next = NLL_MAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        nll_next = res[22:0];
                        sat_next = dropped_reg;
                    end
                    // start a fresh list
                    count_next   = '0;
                    rmax_next    = unseen_score;
                    tval_next    = unseen_score;
                    found_next   = 1'b0;
                    dropped_next = 1'b0;
                    zero_next    = 1'b0;
                    state_next   = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            issued_reg    <= 1'b0;
            count_reg     <= '0;
            rmax_reg      <= UNSEEN_RESET;
            tval_reg      <= UNSEEN_RESET;
            found_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            count_reg     <= count_next;
            rmax_reg      <= rmax_next;
            tval_reg      <= tval_next;
            found_reg     <= found_next;
            dropped_reg   <= dropped_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg     <= mx_next;
        tscore_reg <= tscore_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        term_reg   <= term_next;
        r_reg      <= r_next;
        n_reg      <= n_next;
        sq_reg     <= sq_next;
        d_reg      <= d_next;
        m_reg      <= m_next;
        e_reg      <= e_next;
        frac_reg   <= frac_next;
        fcnt_reg   <= fcnt_next;
        nll_reg    <= nll_next;
        seen_reg   <= seen_next;
        sat_reg    <= sat_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_CANDIDATES))
        else $error("stored count beyond capacity");

    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_ch.last) |=> (state_reg == ST_SETUP))
        else $error("closing transfer did not start the computation");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside the finish step");

    a_list_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (count_reg == '0 && !found_reg))
        else $error("list state not cleared after a result");
`endif

endmodule
